/* hdl/chtvc_pkg.sv */
// ----------------------------------------------------------------------------
// chtvc_pkg
// Shared constants, types and slot arithmetic for the compact hash table.
// ----------------------------------------------------------------------------
package chtvc_pkg;

   localparam int SLOTS      = 1024;
   localparam int ADDR_W     = $clog2(SLOTS);
   localparam int CNT_W      = ADDR_W + 1;
   localparam int QUOT_W     = 16;
   localparam int TSIZE_W    = 11;
   localparam int LIMIT_W    = 7;
   localparam int OFFSET_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int MOD_W      = CNT_W + ADDR_W - 1;
   localparam int STEP_W     = $clog2(ADDR_W);

   localparam logic [TSIZE_W-1:0]  TSIZE_RST = TSIZE_W'(SLOTS);
   localparam logic [QUOT_W-1:0]   EMPTY_RST = '1;
   localparam logic [ADDR_W-1:0]   ROOT_RST  = '0;
   localparam logic [LIMIT_W-1:0]  LIMIT_RST = LIMIT_W'(32);
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_SIZE   = 2'd0,
      CSR_EMPTY_CODE   = 2'd1,
      CSR_ROOT_ADDRESS = 2'd2,
      CSR_BLOCK_LIMIT  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      LOC_NO_EMPTY,
      LOC_NO_GROUP,
      LOC_GROUP
   } locate_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RINIT,
      ST_RMOD,
      ST_CLR,
      ST_CLR_ROOT,
      ST_HMOD,
      ST_RDH,
      ST_LOCD,
      ST_LOCU,
      ST_DISP,
      ST_RDS,
      ST_WUP,
      ST_SHIFT,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic              qc_we;
      logic [ADDR_W-1:0] qc_addr;
      logic [QUOT_W:0]   qc_data;
      logic              v_we;
      logic [ADDR_W-1:0] v_addr;
      logic              v_data;
   } store_wr_type;

   typedef struct packed {
      logic              found;
      logic              added;
      logic [CNT_W-1:0]  off;
      logic [ADDR_W-1:0] slot;
      logic              rej;
   } res_type;

   function automatic logic [ADDR_W-1:0] slot_up(input logic [ADDR_W-1:0] a,
                                                 input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] s;
      s = {1'b0, a} + CNT_W'(1);
      return (s >= n) ? '0 : s[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] slot_down(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0] n);
      logic [CNT_W-1:0] m;
      m = n - CNT_W'(1);
      return (a == '0) ? m[ADDR_W-1:0] : a - ADDR_W'(1);
   endfunction

   function automatic res_type make_res(input logic f, input logic ad,
                                        input logic [CNT_W-1:0] off,
                                        input logic [ADDR_W-1:0] slot,
                                        input logic rej);
      res_type r;
      r.found = f;
      r.added = ad;
      r.off   = off;
      r.slot  = slot;
      r.rej   = rej;
      return r;
   endfunction

endpackage

/* hdl/chtvc_req_if.sv */
// ----------------------------------------------------------------------------
// chtvc_req_if
// Request channel: operation kind, home slot and quotient.
// ----------------------------------------------------------------------------
interface chtvc_req_if;
   logic                         valid;
   logic                         ready;
   logic                         kind;
   logic [chtvc_pkg::ADDR_W-1:0] home_slot;
   logic [chtvc_pkg::QUOT_W-1:0] quotient;

   modport source(output valid, kind, home_slot, quotient, input ready);
   modport sink(input valid, kind, home_slot, quotient, output ready);
endinterface

/* hdl/chtvc_rsp_if.sv */
// ----------------------------------------------------------------------------
// chtvc_rsp_if
// Response channel: search or insert outcome.
// ----------------------------------------------------------------------------
interface chtvc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           found;
   logic                           added;
   logic [chtvc_pkg::OFFSET_W-1:0] group_offset;
   logic [chtvc_pkg::ADDR_W-1:0]   slot_address;
   logic                           overflow;

   modport source(output valid, found, added, group_offset, slot_address, overflow,
                  input ready);
   modport sink(input valid, found, added, group_offset, slot_address, overflow,
                output ready);
endinterface

/* hdl/chtvc_csr_if.sv */
// ----------------------------------------------------------------------------
// chtvc_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface chtvc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [chtvc_pkg::CSR_IDX_W-1:0]  index;
   logic [chtvc_pkg::CSR_DATA_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* hdl/chtvc_store.sv */
// ----------------------------------------------------------------------------
// chtvc_store
// Slot storage: quotient plus change bit, and virgin bit, one read port each.
// ----------------------------------------------------------------------------
module chtvc_store (
   input  logic                            clock,
   input  logic [chtvc_pkg::ADDR_W-1:0]    rd_addr,
   input  chtvc_pkg::store_wr_type         wr,
   output logic [chtvc_pkg::QUOT_W:0]      rd_qc,
   output logic                            rd_v
);

   logic [chtvc_pkg::QUOT_W:0] qc_mem [chtvc_pkg::SLOTS];
   logic                       v_mem  [chtvc_pkg::SLOTS];

   always_ff @(posedge clock) begin
      if (wr.qc_we) begin
         qc_mem[wr.qc_addr] <= wr.qc_data;
      end
      rd_qc <= qc_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wr.v_we) begin
         v_mem[wr.v_addr] <= wr.v_data;
      end
      rd_v <= v_mem[rd_addr];
   end

endmodule

/* hdl/compact_hash_table_vc_bits_top.sv */
// ----------------------------------------------------------------------------
// compact_hash_table_vc_bits_top
// Compact hash table with virgin and change bits over a circular slot array.
// One transaction at a time: the next request is taken once the result sits
//   in the output register.
// Reset and writes of table_size, empty_code or root_address start a clearing
//   pass during which no request is taken.
// ----------------------------------------------------------------------------
module compact_hash_table_vc_bits_top (
   input logic          clock,
   input logic          reset,
   chtvc_req_if.sink    req_bus,
   chtvc_rsp_if.source  rsp_bus,
   chtvc_csr_if.sink    csr_bus
);

   localparam int AW = chtvc_pkg::ADDR_W;
   localparam int CW = chtvc_pkg::CNT_W;
   localparam int QW = chtvc_pkg::QUOT_W;

   // Configuration registers
   logic [chtvc_pkg::TSIZE_W-1:0] tsize_ff;
   logic [QW-1:0]                 empty_code_ff;
   logic [AW-1:0]                 root_ff;
   logic [chtvc_pkg::LIMIT_W-1:0] limit_ff;

   // Sequencer
   chtvc_pkg::state_type  state_ff, state_in;
   logic                  ph_ff, ph_in;
   logic                  kind_ff, kind_in;
   logic [QW-1:0]         quot_ff, quot_in;
   logic [AW-1:0]         md_ff, md_in;
   logic [chtvc_pkg::STEP_W-1:0] k_ff, k_in;
   logic [AW-1:0]         a_ff, a_in;
   logic [CW-1:0]         vc_ff, vc_in;
   logic [CW-1:0]         ones_ff, ones_in;
   logic [CW-1:0]         steps_ff, steps_in;
   logic [CW-1:0]         j_ff, j_in;
   logic [AW-1:0]         empty_ff, empty_in;
   chtvc_pkg::locate_type loc_ff, loc_in;
   logic                  hv_ff, hv_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [AW-1:0]         stop_ff, stop_in;
   logic [AW-1:0]         sh_ff, sh_in;
   logic                  cb_ff, cb_in;
   logic                  vset_ff, vset_in;
   logic                  srch_ff, srch_in;
   logic [AW-1:0]         clr_ff, clr_in;
   logic [CW-1:0]         free_ff, free_in;
   chtvc_pkg::res_type    res_ff, res_in;

   // Output register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_found_ff, rsp_added_ff, rsp_ovf_ff;
   logic [chtvc_pkg::OFFSET_W-1:0]  rsp_off_ff;
   logic [AW-1:0]                   rsp_slot_ff;

   // Storage
   chtvc_pkg::store_wr_type wr;
   logic [AW-1:0]           rd_addr;
   logic [QW:0]             rd_qc;
   logic                    rd_v;

   // Shared terms
   logic [CW-1:0]                 n;
   logic [chtvc_pkg::MOD_W-1:0]   nsh;
   logic [AW-1:0]                 md_step;
   logic [QW-1:0]                 rq;
   logic                          rc, q_hit, q_emp, in_emp, free_lo, cont;
   logic [AW-1:0]                 up_a, down_a, up_sh;
   logic [CW-1:0]                 ones_nx, steps_nx;
   logic                          req_acc, csr_acc, csr_clear, out_free;
   chtvc_pkg::res_type            rej_res;

   chtvc_store u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr      (wr),
      .rd_qc   (rd_qc),
      .rd_v    (rd_v)
   );

   // Clamp the slot count into the legal range
   always_comb begin
      if (tsize_ff < chtvc_pkg::TSIZE_W'(2)) begin
         n = CW'(2);
      end else if (tsize_ff > chtvc_pkg::TSIZE_W'(chtvc_pkg::SLOTS)) begin
         n = CW'(chtvc_pkg::SLOTS);
      end else begin
         n = CW'(tsize_ff);
      end
   end

   // One restoring step of the modulo reduction: subtract n shifted by k
   assign nsh     = chtvc_pkg::MOD_W'(n) << k_ff;
   assign md_step = (chtvc_pkg::MOD_W'(md_ff) >= nsh) ? md_ff - nsh[AW-1:0] : md_ff;

   assign rq       = rd_qc[QW:1];
   assign rc       = rd_qc[0];
   assign q_hit    = (rq == quot_ff);
   assign q_emp    = (rq == empty_code_ff);
   assign in_emp   = (quot_ff == empty_code_ff);
   assign free_lo  = (free_ff < CW'(2));
   assign cont     = !rc && (j_ff < n);
   assign up_a     = chtvc_pkg::slot_up(a_ff, n);
   assign down_a   = chtvc_pkg::slot_down(a_ff, n);
   assign up_sh    = chtvc_pkg::slot_up(sh_ff, n);
   assign ones_nx  = ones_ff + CW'(rc);
   assign steps_nx = steps_ff + CW'(1);
   assign rej_res  = chtvc_pkg::make_res(1'b0, 1'b0, '0, md_ff, 1'b1);

   assign req_acc   = req_bus.valid && req_bus.ready;
   assign csr_acc   = csr_bus.valid && csr_bus.ready;
   assign csr_clear = csr_acc && (csr_bus.index != chtvc_pkg::CSR_BLOCK_LIMIT);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == chtvc_pkg::ST_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.found        = rsp_found_ff;
   assign rsp_bus.added        = rsp_added_ff;
   assign rsp_bus.group_offset = rsp_off_ff;
   assign rsp_bus.slot_address = rsp_slot_ff;
   assign rsp_bus.overflow     = rsp_ovf_ff;

   // Shift reads the slot above the hole; everything else reads the walk pointer
   assign rd_addr = (state_ff == chtvc_pkg::ST_SHIFT) ? up_sh : a_ff;

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         chtvc_pkg::ST_IDLE: begin
            if (req_acc) state_in = chtvc_pkg::ST_HMOD;
         end
         chtvc_pkg::ST_RINIT: state_in = chtvc_pkg::ST_RMOD;
         chtvc_pkg::ST_RMOD: begin
            if (k_ff == '0) state_in = chtvc_pkg::ST_CLR;
         end
         chtvc_pkg::ST_CLR: begin
            if (clr_ff == AW'(chtvc_pkg::SLOTS - 1)) state_in = chtvc_pkg::ST_CLR_ROOT;
         end
         chtvc_pkg::ST_CLR_ROOT: state_in = chtvc_pkg::ST_IDLE;
         chtvc_pkg::ST_HMOD: begin
            if (k_ff == '0) state_in = chtvc_pkg::ST_RDH;
         end
         chtvc_pkg::ST_RDH: begin
            if (ph_ff) begin
               if (kind_ff == chtvc_pkg::KIND_LOOKUP) begin
                  state_in = rd_v ? chtvc_pkg::ST_LOCD : chtvc_pkg::ST_EMIT;
               end else if (in_emp) begin
                  state_in = chtvc_pkg::ST_EMIT;
               end else if (q_emp) begin
                  state_in = free_lo ? chtvc_pkg::ST_EMIT : chtvc_pkg::ST_WRITE;
               end else begin
                  state_in = chtvc_pkg::ST_LOCD;
               end
            end
         end
         chtvc_pkg::ST_LOCD: begin
            if (ph_ff) begin
               if (q_emp) begin
                  state_in = (vc_ff == '0) ? chtvc_pkg::ST_DISP : chtvc_pkg::ST_LOCU;
               end else if (steps_ff >= n) begin
                  state_in = chtvc_pkg::ST_DISP;
               end
            end
         end
         chtvc_pkg::ST_LOCU: begin
            if (ph_ff && (ones_nx == vc_ff || steps_nx >= n)) state_in = chtvc_pkg::ST_DISP;
         end
         chtvc_pkg::ST_DISP: begin
            if (kind_ff == chtvc_pkg::KIND_LOOKUP || hv_ff) begin
               state_in = (loc_ff == chtvc_pkg::LOC_GROUP) ? chtvc_pkg::ST_RDS
                                                           : chtvc_pkg::ST_EMIT;
            end else if (loc_ff == chtvc_pkg::LOC_NO_EMPTY || free_lo) begin
               state_in = chtvc_pkg::ST_EMIT;
            end else if (loc_ff == chtvc_pkg::LOC_GROUP) begin
               state_in = chtvc_pkg::ST_WUP;
            end else begin
               state_in = chtvc_pkg::ST_SHIFT;
            end
         end
         chtvc_pkg::ST_RDS: begin
            if (ph_ff) begin
               if (q_hit) begin
                  state_in = chtvc_pkg::ST_EMIT;
               end else if (kind_ff == chtvc_pkg::KIND_INSERT && q_emp) begin
                  state_in = free_lo ? chtvc_pkg::ST_EMIT : chtvc_pkg::ST_WRITE;
               end else begin
                  state_in = chtvc_pkg::ST_WUP;
               end
            end
         end
         chtvc_pkg::ST_WUP: begin
            if (ph_ff) begin
               if (cont) begin
                  if (srch_ff && q_hit) state_in = chtvc_pkg::ST_EMIT;
               end else if (srch_ff && kind_ff == chtvc_pkg::KIND_LOOKUP) begin
                  state_in = chtvc_pkg::ST_EMIT;
               end else if (srch_ff && free_lo) begin
                  state_in = chtvc_pkg::ST_EMIT;
               end else begin
                  state_in = chtvc_pkg::ST_SHIFT;
               end
            end
         end
         chtvc_pkg::ST_SHIFT: begin
            if (!ph_ff && (sh_ff == stop_ff || steps_ff >= n)) state_in = chtvc_pkg::ST_WRITE;
         end
         chtvc_pkg::ST_WRITE: state_in = chtvc_pkg::ST_EMIT;
         chtvc_pkg::ST_EMIT: begin
            if (out_free) state_in = chtvc_pkg::ST_IDLE;
         end
         default: state_in = chtvc_pkg::ST_RINIT;
      endcase
      // A table-shaping register write restarts the clearing pass
      if (csr_clear) state_in = chtvc_pkg::ST_RINIT;
   end

   // ------------------------------------------------------------------
   // Datapath and memory writes
   // ------------------------------------------------------------------
   always_comb begin
      ph_in    = (state_in == state_ff) ? !ph_ff : 1'b0;
      kind_in  = kind_ff;
      quot_in  = quot_ff;
      md_in    = md_ff;
      k_in     = k_ff;
      a_in     = a_ff;
      vc_in    = vc_ff;
      ones_in  = ones_ff;
      steps_in = steps_ff;
      j_in     = j_ff;
      empty_in = empty_ff;
      loc_in   = loc_ff;
      hv_in    = hv_ff;
      pos_in   = pos_ff;
      stop_in  = stop_ff;
      sh_in    = sh_ff;
      cb_in    = cb_ff;
      vset_in  = vset_ff;
      srch_in  = srch_ff;
      clr_in   = clr_ff;
      free_in  = free_ff;
      res_in   = res_ff;
      wr       = '0;
      case (state_ff)
         chtvc_pkg::ST_IDLE: begin
            if (req_acc) begin
               kind_in = req_bus.kind;
               quot_in = req_bus.quotient;
               md_in   = req_bus.home_slot;
               k_in    = chtvc_pkg::STEP_W'(AW - 1);
            end
         end
         chtvc_pkg::ST_RINIT: begin
            md_in = root_ff;
            k_in  = chtvc_pkg::STEP_W'(AW - 1);
         end
         chtvc_pkg::ST_RMOD: begin
            md_in  = md_step;
            k_in   = k_ff - chtvc_pkg::STEP_W'(1);
            clr_in = '0;
         end
         chtvc_pkg::ST_CLR: begin
            wr.qc_we   = 1'b1;
            wr.qc_addr = clr_ff;
            wr.qc_data = {empty_code_ff, 1'b1};
            wr.v_we    = 1'b1;
            wr.v_addr  = clr_ff;
            wr.v_data  = 1'b0;
            clr_in     = clr_ff + AW'(1);
         end
         chtvc_pkg::ST_CLR_ROOT: begin
            // Root marker is one below the empty code
            wr.qc_we   = 1'b1;
            wr.qc_addr = md_ff;
            wr.qc_data = {empty_code_ff - QW'(1), 1'b1};
            wr.v_we    = 1'b1;
            wr.v_addr  = md_ff;
            wr.v_data  = 1'b1;
            free_in    = n - CW'(1);
         end
         chtvc_pkg::ST_HMOD: begin
            md_in = md_step;
            k_in  = k_ff - chtvc_pkg::STEP_W'(1);
            a_in  = md_step;
         end
         chtvc_pkg::ST_RDH: begin
            if (ph_ff) begin
               hv_in    = rd_v;
               vc_in    = CW'(rd_v);
               a_in     = down_a;
               steps_in = '0;
               if (kind_ff == chtvc_pkg::KIND_LOOKUP) begin
                  res_in = chtvc_pkg::make_res(1'b0, 1'b0, '0, md_ff, 1'b0);
               end else if (in_emp || (q_emp && free_lo)) begin
                  res_in = rej_res;
               end else if (q_emp) begin
                  pos_in  = md_ff;
                  cb_in   = 1'b1;
                  vset_in = 1'b1;
                  res_in  = chtvc_pkg::make_res(1'b0, 1'b1, '0, md_ff, 1'b0);
               end
            end
         end
         chtvc_pkg::ST_LOCD: begin
            if (ph_ff) begin
               if (q_emp) begin
                  empty_in = a_ff;
                  loc_in   = chtvc_pkg::LOC_NO_GROUP;
                  a_in     = up_a;
                  steps_in = '0;
                  ones_in  = '0;
               end else if (steps_ff >= n) begin
                  loc_in = chtvc_pkg::LOC_NO_EMPTY;
               end else begin
                  vc_in    = vc_ff + CW'(rd_v);
                  a_in     = down_a;
                  steps_in = steps_nx;
               end
            end
         end
         chtvc_pkg::ST_LOCU: begin
            if (ph_ff) begin
               ones_in = ones_nx;
               if (ones_nx == vc_ff) begin
                  loc_in = chtvc_pkg::LOC_GROUP;
               end else begin
                  a_in     = up_a;
                  steps_in = steps_nx;
               end
            end
         end
         chtvc_pkg::ST_DISP: begin
            if (kind_ff == chtvc_pkg::KIND_LOOKUP) begin
               res_in = chtvc_pkg::make_res(1'b0, 1'b0, '0, md_ff, 1'b0);
            end else if (hv_ff || loc_ff == chtvc_pkg::LOC_NO_EMPTY || free_lo) begin
               res_in = rej_res;
            end else if (loc_ff == chtvc_pkg::LOC_GROUP) begin
               // Walk to the end of the located group
               a_in    = up_a;
               j_in    = '0;
               srch_in = 1'b0;
            end else begin
               // New group goes straight into the empty slot
               pos_in   = empty_ff;
               stop_in  = empty_ff;
               sh_in    = empty_ff;
               steps_in = '0;
               cb_in    = 1'b1;
               vset_in  = 1'b1;
               res_in   = chtvc_pkg::make_res(1'b0, 1'b1, '0, empty_ff, 1'b0);
            end
         end
         chtvc_pkg::ST_RDS: begin
            if (ph_ff) begin
               if (q_hit) begin
                  res_in = chtvc_pkg::make_res(1'b1, 1'b0, '0, a_ff, 1'b0);
               end else if (kind_ff == chtvc_pkg::KIND_INSERT && q_emp) begin
                  if (free_lo) begin
                     res_in = rej_res;
                  end else begin
                     pos_in  = a_ff;
                     cb_in   = 1'b0;
                     vset_in = 1'b0;
                     res_in  = chtvc_pkg::make_res(1'b0, 1'b1, '0, a_ff, 1'b0);
                  end
               end else begin
                  a_in    = up_a;
                  j_in    = CW'(1);
                  srch_in = 1'b1;
               end
            end
         end
         chtvc_pkg::ST_WUP: begin
            if (ph_ff) begin
               if (cont) begin
                  if (srch_ff && q_hit) begin
                     res_in = chtvc_pkg::make_res(1'b1, 1'b0, j_ff, a_ff, 1'b0);
                  end else begin
                     a_in = up_a;
                     j_in = j_ff + CW'(1);
                  end
               end else if (srch_ff && kind_ff == chtvc_pkg::KIND_LOOKUP) begin
                  res_in = chtvc_pkg::make_res(1'b0, 1'b0, j_ff - CW'(1), down_a, 1'b0);
               end else if (srch_ff) begin
                  // Append at the group end
                  if (free_lo) begin
                     res_in = rej_res;
                  end else begin
                     pos_in   = down_a;
                     stop_in  = down_a;
                     sh_in    = empty_ff;
                     steps_in = '0;
                     cb_in    = 1'b0;
                     vset_in  = 1'b0;
                     res_in   = chtvc_pkg::make_res(1'b0, 1'b1, j_ff, down_a, 1'b0);
                  end
               end else begin
                  // Open a new group just below the following one
                  pos_in   = down_a;
                  stop_in  = a_ff;
                  sh_in    = empty_ff;
                  steps_in = '0;
                  cb_in    = 1'b1;
                  vset_in  = 1'b1;
                  res_in   = chtvc_pkg::make_res(1'b0, 1'b1, '0, down_a, 1'b0);
               end
            end
         end
         chtvc_pkg::ST_SHIFT: begin
            if (ph_ff) begin
               // Move the slot above down into the hole, then advance the hole
               wr.qc_we   = 1'b1;
               wr.qc_addr = sh_ff;
               wr.qc_data = rd_qc;
               sh_in      = up_sh;
               steps_in   = steps_nx;
            end
         end
         chtvc_pkg::ST_WRITE: begin
            wr.qc_we   = 1'b1;
            wr.qc_addr = pos_ff;
            wr.qc_data = {quot_ff, cb_ff};
            wr.v_we    = vset_ff;
            wr.v_addr  = md_ff;
            wr.v_data  = 1'b1;
            free_in    = free_ff - CW'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = (state_ff == chtvc_pkg::ST_EMIT) ? 1'b1
                       : (rsp_valid_ff && !rsp_bus.ready);

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= chtvc_pkg::ST_RINIT;
         ph_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tsize_ff      <= chtvc_pkg::TSIZE_RST;
         empty_code_ff <= chtvc_pkg::EMPTY_RST;
         root_ff       <= chtvc_pkg::ROOT_RST;
         limit_ff      <= chtvc_pkg::LIMIT_RST;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_acc) begin
            case (csr_bus.index)
               chtvc_pkg::CSR_TABLE_SIZE:
                  tsize_ff <= csr_bus.data[chtvc_pkg::TSIZE_W-1:0];
               chtvc_pkg::CSR_EMPTY_CODE:   empty_code_ff <= csr_bus.data;
               chtvc_pkg::CSR_ROOT_ADDRESS: root_ff <= csr_bus.data[AW-1:0];
               chtvc_pkg::CSR_BLOCK_LIMIT:
                  limit_ff <= csr_bus.data[chtvc_pkg::LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      quot_ff  <= quot_in;
      md_ff    <= md_in;
      k_ff     <= k_in;
      a_ff     <= a_in;
      vc_ff    <= vc_in;
      ones_ff  <= ones_in;
      steps_ff <= steps_in;
      j_ff     <= j_in;
      empty_ff <= empty_in;
      loc_ff   <= loc_in;
      hv_ff    <= hv_in;
      pos_ff   <= pos_in;
      stop_ff  <= stop_in;
      sh_ff    <= sh_in;
      cb_ff    <= cb_in;
      vset_ff  <= vset_in;
      srch_ff  <= srch_in;
      clr_ff   <= clr_in;
      free_ff  <= free_in;
      res_ff   <= res_in;
   end

   // Load the output register; saturate the offset, raise overflow at or past the limit
   always_ff @(posedge clock) begin
      if (state_ff == chtvc_pkg::ST_EMIT && out_free) begin
         rsp_found_ff <= res_ff.found;
         rsp_added_ff <= res_ff.added;
         rsp_slot_ff  <= res_ff.slot;
         rsp_off_ff   <= (res_ff.off > CW'(chtvc_pkg::OFFSET_MAX)) ? chtvc_pkg::OFFSET_MAX
                         : res_ff.off[chtvc_pkg::OFFSET_W-1:0];
         rsp_ovf_ff   <= !res_ff.rej && (res_ff.off >= CW'(limit_ff));
      end
   end

endmodule

/* hdl/chtvc_checker.sv */
// ----------------------------------------------------------------------------
// chtvc_checker
// Port-level checks for the compact hash table, bound to the top level.
// ----------------------------------------------------------------------------
module chtvc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_found,
   input logic                             rsp_added,
   input logic [chtvc_pkg::ADDR_W-1:0]     rsp_slot_address,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [chtvc_pkg::CSR_IDX_W-1:0]  csr_index
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot_address))
      else $error("response dropped or changed while stalled");

   // Never report a hit and a new entry together
   a_found_added: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_added))
      else $error("found and added both set");

   // One transaction in flight: a request is not taken straight after another
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // A table-shaping write starts a clear that blocks requests
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index != chtvc_pkg::CSR_BLOCK_LIMIT) |=> !req_ready)
      else $error("request taken during clear");

endmodule

bind compact_hash_table_vc_bits_top chtvc_checker u_chtvc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_found        (rsp_bus.found),
   .rsp_added        (rsp_bus.added),
   .rsp_slot_address (rsp_bus.slot_address),
   .csr_valid        (csr_bus.valid),
   .csr_ready        (csr_bus.ready),
   .csr_index        (csr_bus.index)
);

/* sim/compact_hash_table_vc_bits_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// compact_hash_table_vc_bits_top_test
// Self-checking bench for the compact hash table. A behavioural copy of the
// table (slots, virgin and change bits) predicts every response. Stimulus
// runs through a list of register settings, each followed by a burst of
// clustered inserts and lookups, with random idling on both channels.
// ----------------------------------------------------------------------------
module compact_hash_table_vc_bits_top_test;

   typedef struct {
      bit        kind;
      bit [9:0]  home;
      bit [15:0] quot;
   } hash_req_type;

   typedef struct {
      bit       found;
      bit       added;
      bit [5:0] offset;
      bit [9:0] slot;
      bit       ovf;
   } hash_outcome_type;

   logic clock;
   logic reset;

   chtvc_req_if req_bus();
   chtvc_rsp_if rsp_bus();
   chtvc_csr_if csr_bus();

   compact_hash_table_vc_bits_top uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the table and its registers
   bit [15:0]   tbl_q [chtvc_pkg::SLOTS];
   bit          tbl_v [chtvc_pkg::SLOTS];
   bit          tbl_c [chtvc_pkg::SLOTS];
   int unsigned cfg_size, cfg_empty, cfg_root, cfg_limit;

   hash_req_type     pend_reqs[$];
   hash_outcome_type exp_outcomes[$];
   hash_req_type     drv_item;

   int send_idle;
   int recv_stall;
   int errors;
   int n_sent, n_checked, n_found, n_added, n_ovf, n_phases;
   int quiet_cycles;

   // Stimulus-side memory of inserted keys, for lookups that should hit
   bit [9:0]  known_home[$];
   bit [15:0] known_quot[$];

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic int unsigned size_now();
      if (cfg_size < 2) return 2;
      if (cfg_size > chtvc_pkg::SLOTS) return chtvc_pkg::SLOTS;
      return cfg_size;
   endfunction

   function automatic int unsigned step_up(int unsigned a, int unsigned n);
      return (a + 1 >= n) ? 0 : a + 1;
   endfunction

   function automatic int unsigned step_down(int unsigned a, int unsigned n);
      return (a == 0) ? n - 1 : a - 1;
   endfunction

   function automatic void clear_shadow();
      int unsigned r;
      r = cfg_root % size_now();
      for (int i = 0; i < chtvc_pkg::SLOTS; i++) begin
         tbl_q[i] = cfg_empty[15:0];
         tbl_v[i] = 0;
         tbl_c[i] = 1;
      end
      tbl_q[r] = cfg_empty[15:0] - 16'd1;
      tbl_v[r] = 1;
   endfunction

   // Find the group of a home slot: 0 no empty slot, 1 no group, 2 group found
   function automatic int find_group(int unsigned home, int unsigned n,
                                     output int unsigned emp, output int unsigned st);
      int unsigned vc, a, steps, ones;
      emp = 0;
      st = 0;
      vc = 32'(tbl_v[home]);
      a = step_down(home, n);
      steps = 0;
      ones = 0;
      while (tbl_q[a] != cfg_empty[15:0] && steps < n) begin
         vc += 32'(tbl_v[a]);
         a = step_down(a, n);
         steps++;
      end
      if (tbl_q[a] != cfg_empty[15:0]) return chtvc_pkg::LOC_NO_EMPTY;
      emp = a;
      if (vc == 0) return chtvc_pkg::LOC_NO_GROUP;
      a = step_up(a, n);
      for (steps = 0; steps < n; steps++) begin
         if (tbl_c[a]) ones++;
         if (ones == vc) begin
            st = a;
            return chtvc_pkg::LOC_GROUP;
         end
         a = step_up(a, n);
      end
      return chtvc_pkg::LOC_NO_GROUP;
   endfunction

   function automatic int unsigned count_free(int unsigned n);
      int unsigned c;
      c = 0;
      for (int unsigned i = 0; i < n; i++)
         if (tbl_q[i] == cfg_empty[15:0]) c++;
      return c;
   endfunction

   function automatic void slide_down(int unsigned e, int unsigned stop, int unsigned n);
      int unsigned steps, t;
      steps = 0;
      while (e != stop && steps < n) begin
         t = step_up(e, n);
         tbl_q[e] = tbl_q[t];
         tbl_c[e] = tbl_c[t];
         e = t;
         steps++;
      end
   endfunction

   function automatic hash_outcome_type outcome(bit f, bit ad, int unsigned off,
                                                int unsigned slot);
      hash_outcome_type o;
      o.found  = f;
      o.added  = ad;
      o.offset = (off > 63) ? 6'd63 : off[5:0];
      o.slot   = slot[9:0];
      o.ovf    = (off >= cfg_limit);
      return o;
   endfunction

   function automatic hash_outcome_type predict_op(bit kind, bit [9:0] home_in,
                                                   bit [15:0] q);
      int unsigned      n, home, emp, st, a, j, pos;
      int               r;
      hash_outcome_type rej;
      n = size_now();
      home = home_in % n;
      rej = outcome(0, 0, 0, home);
      rej.ovf = 0;
      if (kind == chtvc_pkg::KIND_LOOKUP) begin
         if (!tbl_v[home]) return outcome(0, 0, 0, home);
         r = find_group(home, n, emp, st);
         if (r != chtvc_pkg::LOC_GROUP) return outcome(0, 0, 0, home);
         if (tbl_q[st] == q) return outcome(1, 0, 0, st);
         a = step_up(st, n);
         j = 1;
         while (tbl_c[a] == 0 && j < n) begin
            if (tbl_q[a] == q) return outcome(1, 0, j, a);
            a = step_up(a, n);
            j++;
         end
         return outcome(0, 0, j - 1, step_down(a, n));
      end
      if (q == cfg_empty[15:0]) return rej;
      // home slot empty: open a group in place
      if (tbl_q[home] == cfg_empty[15:0]) begin
         if (count_free(n) < 2) return rej;
         tbl_q[home] = q;
         tbl_v[home] = 1;
         tbl_c[home] = 1;
         return outcome(0, 1, 0, home);
      end
      r = find_group(home, n, emp, st);
      // no group yet for this home: open one after the preceding group
      if (!tbl_v[home]) begin
         if (r == chtvc_pkg::LOC_NO_EMPTY || count_free(n) < 2) return rej;
         if (r == chtvc_pkg::LOC_GROUP) begin
            a = step_up(st, n);
            j = 0;
            while (tbl_c[a] == 0 && j < n) begin
               a = step_up(a, n);
               j++;
            end
            slide_down(emp, a, n);
            pos = step_down(a, n);
         end else begin
            pos = emp;
         end
         tbl_q[pos] = q;
         tbl_c[pos] = 1;
         tbl_v[home] = 1;
         return outcome(0, 1, 0, pos);
      end
      if (r != chtvc_pkg::LOC_GROUP) return rej;
      if (tbl_q[st] == q) return outcome(1, 0, 0, st);
      if (tbl_q[st] == cfg_empty[15:0]) begin
         if (count_free(n) < 2) return rej;
         tbl_q[st] = q;
         tbl_c[st] = 0;
         return outcome(0, 1, 0, st);
      end
      a = step_up(st, n);
      j = 1;
      while (tbl_c[a] == 0 && j < n) begin
         if (tbl_q[a] == q) return outcome(1, 0, j, a);
         a = step_up(a, n);
         j++;
      end
      // append to the group end, shifting the run down by one
      if (count_free(n) < 2) return rej;
      a = step_down(a, n);
      slide_down(emp, a, n);
      tbl_q[a] = q;
      tbl_c[a] = 0;
      return outcome(0, 1, j, a);
   endfunction

   // ------------------------------------------------------------------
   // Clock, reset and watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Count cycles with no transaction on any channel; bail out when stuck
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 60000) begin
         $display("%0t: watchdog expired, %0d responses outstanding", $time,
                  exp_outcomes.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Request driver: predict on acceptance, then present the next one
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            exp_outcomes.insert(exp_outcomes.size(),
                                predict_op(req_bus.kind, req_bus.home_slot,
                                           req_bus.quotient));
            n_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pend_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
               drv_item = pend_reqs.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.kind      <= drv_item.kind;
               req_bus.home_slot <= drv_item.home;
               req_bus.quotient  <= drv_item.quot;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor: stall at random, compare against the oldest entry
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      hash_outcome_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_stall);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (exp_outcomes.size() == 0) begin
               $display("%0t: unexpected response slot %0d", $time, rsp_bus.slot_address);
               errors++;
            end else begin
               want = exp_outcomes.pop_front();
               n_checked++;
               n_found += 32'(want.found);
               n_added += 32'(want.added);
               n_ovf   += 32'(want.ovf);
               if (rsp_bus.found !== want.found) begin
                  $display("%0t: found exp %0d got %0d", $time, want.found, rsp_bus.found);
                  errors++;
               end
               if (rsp_bus.added !== want.added) begin
                  $display("%0t: added exp %0d got %0d", $time, want.added, rsp_bus.added);
                  errors++;
               end
               if (rsp_bus.group_offset !== want.offset) begin
                  $display("%0t: group_offset exp %0d got %0d", $time, want.offset,
                           rsp_bus.group_offset);
                  errors++;
               end
               if (rsp_bus.slot_address !== want.slot) begin
                  $display("%0t: slot_address exp %0d got %0d", $time, want.slot,
                           rsp_bus.slot_address);
                  errors++;
               end
               if (rsp_bus.overflow !== want.ovf) begin
                  $display("%0t: overflow exp %0d got %0d", $time, want.ovf,
                           rsp_bus.overflow);
                  errors++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencing helpers
   // ------------------------------------------------------------------
   // Write one register; the shadow follows at the accepting edge
   task automatic write_reg(chtvc_pkg::csr_index_type idx, bit [15:0] d);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      case (idx)
         chtvc_pkg::CSR_TABLE_SIZE: begin
            cfg_size = 32'(d[10:0]);
            clear_shadow();
         end
         chtvc_pkg::CSR_EMPTY_CODE: begin
            cfg_empty = 32'(d);
            clear_shadow();
         end
         chtvc_pkg::CSR_ROOT_ADDRESS: begin
            cfg_root = 32'(d[9:0]);
            clear_shadow();
         end
         default: cfg_limit = 32'(d[6:0]);
      endcase
      known_home.delete();
      known_quot.delete();
   endtask

   task automatic push_req(bit kind, bit [9:0] home, bit [15:0] q);
      hash_req_type it;
      it.kind = kind;
      it.home = home;
      it.quot = q;
      pend_reqs.insert(pend_reqs.size(), it);
      if (kind == chtvc_pkg::KIND_INSERT) begin
         known_home.insert(known_home.size(), home);
         known_quot.insert(known_quot.size(), q);
      end
   endtask

   // Hold until every queued request has been answered
   task automatic drain();
      while (pend_reqs.size() != 0 || req_bus.valid || exp_outcomes.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Clustered traffic: mostly inserts near a few hot homes and lookups that
   // should hit, with a tail of random lookups, duplicate and random inserts and inserts of the empty code
   task automatic burst(int count, int spread);
      bit [9:0] hot [4];
      int       r, k;
      for (int i = 0; i < 4; i++) hot[i] = 10'($urandom_range(1023));
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         if (r < 45)
            push_req(chtvc_pkg::KIND_INSERT,
                     10'(hot[$urandom_range(3)] + $urandom_range(spread)),
                     16'($urandom_range(65535)));
         else if (r < 80 && known_home.size() != 0) begin
            k = $urandom_range(known_home.size() - 1);
            push_req(chtvc_pkg::KIND_LOOKUP, known_home[k], known_quot[k]);
         end else if (r < 88)
            push_req(chtvc_pkg::KIND_LOOKUP, 10'($urandom_range(1023)),
                     16'($urandom_range(65535)));
         else if (r < 92)
            push_req(chtvc_pkg::KIND_INSERT, 10'($urandom_range(1023)), cfg_empty[15:0]);
         else if (r < 96 && known_home.size() != 0) begin
            // duplicate insert: reports found unless the first insert was rejected
            k = $urandom_range(known_home.size() - 1);
            push_req(chtvc_pkg::KIND_INSERT, known_home[k], known_quot[k]);
         end else
            push_req(chtvc_pkg::KIND_INSERT, 10'($urandom_range(1023)),
                     16'($urandom_range(65535)));
      end
      drain();
      n_phases++;
   endtask

   // Select the idling pattern by run progress
   task automatic set_idling(int stage);
      case (stage)
         0: begin
            send_idle  = 10;
            recv_stall = 82;
         end
         1: begin
            send_idle  = 82;
            recv_stall = 10;
         end
         default: begin
            send_idle  = 0;
            recv_stall = 0;
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      errors = 0;
      n_sent = 0;
      n_checked = 0;
      n_found = 0;
      n_added = 0;
      n_ovf = 0;
      n_phases = 0;
      quiet_cycles = 0;
      req_bus.valid = 1'b0;
      req_bus.kind = chtvc_pkg::KIND_INSERT;
      req_bus.home_slot = '0;
      req_bus.quotient = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = chtvc_pkg::CSR_TABLE_SIZE;
      csr_bus.data = '0;
      cfg_size = 1024;
      cfg_empty = 65535;
      cfg_root = 0;
      cfg_limit = 32;
      clear_shadow();
      set_idling(0);
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: default settings, root group, empty code, misses, duplicates
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd5, 16'h0000);     // lookup with no group
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd0, 16'hFFFE);     // root marker is found
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd0, 16'h1234);     // miss inside root group
      push_req(chtvc_pkg::KIND_INSERT, 10'd0, 16'hFFFF);     // empty code is refused
      push_req(chtvc_pkg::KIND_INSERT, 10'd0, 16'h0001);     // append to root group
      push_req(chtvc_pkg::KIND_INSERT, 10'd0, 16'h0001);     // duplicate
      push_req(chtvc_pkg::KIND_INSERT, 10'd1, 16'h0002);     // home empty, new group in place
      push_req(chtvc_pkg::KIND_INSERT, 10'd1023, 16'h0003);  // top slot, wraps
      push_req(chtvc_pkg::KIND_INSERT, 10'd1023, 16'h0000);
      push_req(chtvc_pkg::KIND_INSERT, 10'd1022, 16'hFFFE);
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd1023, 16'h0000);
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd1023, 16'h7777);
      push_req(chtvc_pkg::KIND_INSERT, 10'd512, 16'h8000);
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd512, 16'h8000);
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd511, 16'h8000);
      drain();

      // Full-size table, long group at one home: offsets run past 63
      write_reg(chtvc_pkg::CSR_EMPTY_CODE, 16'h1234);
      write_reg(chtvc_pkg::CSR_ROOT_ADDRESS, 16'd1023);
      write_reg(chtvc_pkg::CSR_BLOCK_LIMIT, 16'd64);
      for (int i = 0; i < 70; i++)
         push_req(chtvc_pkg::KIND_INSERT, 10'd300, 16'(i * 7 + 1));
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd300, 16'd484);
      push_req(chtvc_pkg::KIND_LOOKUP, 10'd300, 16'hAAAA);
      drain();

      // Small table filled to rejection, every nonzero offset overflows
      write_reg(chtvc_pkg::CSR_TABLE_SIZE, 16'd16);
      write_reg(chtvc_pkg::CSR_EMPTY_CODE, 16'h0000);
      write_reg(chtvc_pkg::CSR_ROOT_ADDRESS, 16'd15);
      write_reg(chtvc_pkg::CSR_BLOCK_LIMIT, 16'd1);
      burst(60, 3);

      // Out-of-range sizes clamp to the two ends
      write_reg(chtvc_pkg::CSR_TABLE_SIZE, 16'd0);
      burst(20, 1);
      write_reg(chtvc_pkg::CSR_TABLE_SIZE, 16'hFFFF);
      write_reg(chtvc_pkg::CSR_BLOCK_LIMIT, 16'h00FF);
      burst(60, 15);

      // Random settings: small tables mostly, the odd full-size one
      while (n_sent < 1800) begin
         set_idling((n_sent * 3) / 1800);
         if ($urandom_range(7) == 0)
            write_reg(chtvc_pkg::CSR_TABLE_SIZE, 16'd1024);
         else
            write_reg(chtvc_pkg::CSR_TABLE_SIZE, 16'($urandom_range(2, 96)));
         if ($urandom_range(3) == 0)
            write_reg(chtvc_pkg::CSR_EMPTY_CODE, 16'($urandom_range(65535)));
         if ($urandom_range(2) == 0)
            write_reg(chtvc_pkg::CSR_ROOT_ADDRESS, 16'($urandom_range(1023)));
         write_reg(chtvc_pkg::CSR_BLOCK_LIMIT, 16'($urandom_range(1, 64)));
         burst($urandom_range(60, 120), $urandom_range(1, 12));
      end

      repeat (100) @(posedge clock);
      $display("Covered %0d requests over %0d register settings: %0d found, %0d added,",
               n_sent, n_phases, n_found, n_added);
      $display("%0d overflow flags, %0d responses compared.", n_ovf, n_checked);
      if (errors == 0 && exp_outcomes.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
